// ===== src/prqs_pkg.sv =====
// Shared types, codes and defaults of the priority ready-queue scheduler.
`default_nettype none
package prqs_pkg;

  localparam int DEF_TASK_COUNT   = 16;
  localparam int DEF_TOP_PRIORITY = 31;
  localparam logic [4:0] FALLBACK_PRIO_RESET = 5'd8;
  localparam int SCAN_CHUNK = 8;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_YIELD  = 2'd1,
    CMD_EXIT   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    RES_OK     = 2'd0,
    RES_INVAL  = 2'd1,
    RES_NOSLOT = 2'd2
  } res_t;

  typedef enum logic [2:0] {
    TS_INVALID  = 3'd0,
    TS_READY    = 3'd1,
    TS_RUNNING  = 3'd2,
    TS_FINISHED = 3'd4,
    TS_IDLE     = 3'd5
  } task_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FREE_WAIT,
    S_READY_WAIT,
    S_DQ_RD,
    S_DQ_CHK,
    S_DQ_NEXT,
    S_DQ_HEAD,
    S_DQ_END,
    S_ENQ,
    S_ENQ_LINK,
    S_FINISH
  } sched_state_t;

  typedef struct packed {
    logic start;
    logic desc;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_res_t;

endpackage
`default_nettype wire

// ===== src/priority_ready_queue_scheduler.sv =====
// Top level: task table, per-priority ready queues, ready bitmap and sequencer.
//
//  channel   dir  handshake            contents
//  s_*       in   s_tvalid / s_tready  tdata: priority_req, entry_address; tuser: command
//  m_*       out  m_tvalid / m_tready  tdata: result fields; tuser: status
//  cfg_*     in   cfg_we               cfg_wdata: fallback priority
//
// In one transaction the shared bit-search unit walks the free-slot or ready vector 8 bits
// a cycle, then queue pointer updates go through the registered read ports of the memories.
// s_tready is high only while the sequencer is idle; a finished result waits in the output
// register and the next command is taken meanwhile, so only a result that meets an unread
// one stalls in finish. No clearing pass after reset: queue emptiness lives in the ready
// bitmap.
`default_nettype none
module priority_ready_queue_scheduler #(
  parameter int TASK_COUNT   = prqs_pkg::DEF_TASK_COUNT,
  parameter int TOP_PRIORITY = prqs_pkg::DEF_TOP_PRIORITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] priority_req, [39:8] entry_address
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] new_task_id, [4] switched, [8:5] from_task,
                                 // [12:9] to_task, [17:13] to_prio, [23:18] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  import prqs_pkg::*;

  localparam int TW   = $clog2(TASK_COUNT);
  localparam int PW   = $clog2(TOP_PRIORITY + 1);
  localparam int QW   = (TOP_PRIORITY > 1) ? $clog2(TOP_PRIORITY) : 1;
  localparam int SW   = (TASK_COUNT > TOP_PRIORITY) ? TASK_COUNT : TOP_PRIORITY;
  localparam int SNCH = (SW + SCAN_CHUNK - 1) / SCAN_CHUNK;
  localparam int SIW  = $clog2(SNCH * SCAN_CHUNK);

  sched_state_t state, state_next;

  logic [4:0]    fallback_prio;
  logic [1:0]    cmd;
  logic [PW-1:0] prio;
  logic          arg_ok;
  logic [31:0]   entry;
  logic [TW-1:0] cur;
  logic [TW-1:0] from_id;
  logic [TW-1:0] new_id;
  logic [TW-1:0] nt;
  logic [TW-1:0] enq_t;
  logic [QW-1:0] qa;
  res_t          res_code;
  task_state_t   cur_st;
  logic [PW-1:0] cur_pri;

  task_state_t   task_status   [TASK_COUNT];
  logic [PW-1:0] task_priority [TASK_COUNT];
  logic [TW-1:0] task_next     [TASK_COUNT];
  logic [31:0]   task_entry    [TASK_COUNT];
  logic [TW-1:0] queue_head    [TOP_PRIORITY];
  logic [TW-1:0] queue_tail    [TOP_PRIORITY];
  logic [TOP_PRIORITY-1:0] ready_bitmap;

  logic [TW-1:0] head_rd;
  logic [TW-1:0] tail_rd;
  logic [TW-1:0] next_rd;

  logic [TASK_COUNT-1:0] free_vec;
  logic [SW-1:0]         scan_vec;
  scan_req_t             scan_req;
  scan_res_t             scan_res;
  logic [SIW-1:0]        scan_idx;

  logic [7:0]    eff_prio;
  logic          in_ok;
  logic          accept;
  logic [PW-1:0] found_p;
  logic [TW-1:0] found_t;
  task_state_t   cur_rd;
  task_state_t   cur_st_next;
  logic [PW-1:0] cur_pri_rd;
  logic          cur_pri_ok;

  // control strobes
  logic          st_we;
  logic [TW-1:0] st_wa;
  task_state_t   st_wd;
  logic          slot_we;
  logic          head_we;
  logic [TW-1:0] head_wd;
  logic          tail_we;
  logic          next_we;
  logic          rdy_set;
  logic          rdy_clr;
  logic          out_load;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);

  // an oversized request falls back to the configured priority
  assign eff_prio = (s_tdata[7:0] > 8'(TOP_PRIORITY)) ? {3'b000, fallback_prio} : s_tdata[7:0];
  assign in_ok    = (eff_prio != 8'd0) && (eff_prio <= 8'(TOP_PRIORITY)) &&
                    (s_tdata[39:8] != 32'd0);

  always_comb begin
    for (int i = 0; i < TASK_COUNT; i++) begin
      free_vec[i] = (task_status[i] == TS_INVALID);
    end
  end

  assign scan_vec   = (cmd == CMD_CREATE) ? SW'(free_vec) : SW'(ready_bitmap);
  assign found_p    = PW'(scan_idx) + PW'(1);
  assign found_t    = scan_idx[TW-1:0];
  assign cur_rd     = task_status[cur];
  assign cur_pri_rd = task_priority[cur];
  assign cur_pri_ok = (cur_pri != '0) && (cur_pri <= PW'(TOP_PRIORITY));

  // exit frees the slot at once; the idle task cannot be freed
  assign cur_st_next = ((cmd == CMD_EXIT && cur != '0) || cur_rd == TS_FINISHED) ?
                       TS_INVALID : cur_rd;

  prqs_scan #(.W(SW)) u_scan (
    .clk (clk),
    .rst (rst),
    .req (scan_req),
    .vec (scan_vec),
    .res (scan_res),
    .idx (scan_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    scan_req   = '0;
    st_we      = 1'b0;
    st_wa      = cur;
    st_wd      = TS_INVALID;
    slot_we    = 1'b0;
    head_we    = 1'b0;
    head_wd    = enq_t;
    tail_we    = 1'b0;
    next_we    = 1'b0;
    rdy_set    = 1'b0;
    rdy_clr    = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (cmd)
          CMD_CREATE: begin
            if (arg_ok) begin
              scan_req.start = 1'b1;
              state_next     = S_FREE_WAIT;
            end else begin
              state_next = S_FINISH;
            end
          end
          CMD_YIELD, CMD_EXIT: begin
            st_we          = (cur_st_next != cur_rd);
            st_wd          = cur_st_next;
            scan_req.start = 1'b1;
            scan_req.desc  = 1'b1;
            state_next     = S_READY_WAIT;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_FREE_WAIT: begin
        if (scan_res.done) begin
          if (scan_res.found) begin
            st_we      = 1'b1;
            st_wa      = found_t;
            st_wd      = TS_READY;
            slot_we    = 1'b1;
            state_next = S_ENQ;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_READY_WAIT: begin
        if (scan_res.done) begin
          if (!scan_res.found || (cur_st == TS_RUNNING && cur_pri > found_p)) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_DQ_RD;
          end
        end
      end
      S_DQ_RD: state_next = S_DQ_CHK;
      S_DQ_CHK: begin
        // preempted task goes back to ready before its re-queue
        st_we = (cur_st == TS_RUNNING);
        st_wd = TS_READY;
        if (head_rd == tail_rd) begin
          rdy_clr    = 1'b1;
          state_next = S_DQ_END;
        end else begin
          state_next = S_DQ_NEXT;
        end
      end
      S_DQ_NEXT: state_next = S_DQ_HEAD;
      S_DQ_HEAD: begin
        head_we    = 1'b1;
        head_wd    = next_rd;
        state_next = S_DQ_END;
      end
      S_DQ_END: begin
        st_we = 1'b1;
        st_wa = nt;
        st_wd = TS_RUNNING;
        state_next = (cur_st == TS_RUNNING && cur_pri_ok) ? S_ENQ : S_FINISH;
      end
      S_ENQ: begin
        if (ready_bitmap[qa]) begin
          state_next = S_ENQ_LINK;
        end else begin
          head_we    = 1'b1;
          tail_we    = 1'b1;
          rdy_set    = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_ENQ_LINK: begin
        next_we    = 1'b1;
        tail_we    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd      <= s_tuser;
            prio     <= eff_prio[PW-1:0];
            arg_ok   <= in_ok;
            entry    <= s_tdata[39:8];
            from_id  <= cur;
            new_id   <= '0;
            res_code <= RES_OK;
          end
        end
        S_DECODE: begin
          cur_st  <= cur_st_next;
          cur_pri <= cur_pri_rd;
          if (cmd == CMD_CREATE) begin
            if (!arg_ok) res_code <= RES_INVAL;
          end else if (cmd != CMD_YIELD && cmd != CMD_EXIT) begin
            res_code <= RES_INVAL;
          end
        end
        S_FREE_WAIT: begin
          if (scan_res.done) begin
            if (scan_res.found) begin
              new_id <= found_t;
              enq_t  <= found_t;
              qa     <= QW'(prio - PW'(1));
            end else begin
              res_code <= RES_NOSLOT;
            end
          end
        end
        S_READY_WAIT: begin
          if (scan_res.done) begin
            if (!scan_res.found) begin
              if (cur_st != TS_RUNNING && cur_st != TS_IDLE) cur <= '0;
            end
            qa <= scan_idx[QW-1:0];
          end
        end
        S_DQ_CHK: nt <= head_rd;
        S_DQ_END: begin
          cur   <= nt;
          enq_t <= cur;
          qa    <= QW'(cur_pri - PW'(1));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback_prio <= FALLBACK_PRIO_RESET;
    end else if (cfg_we) begin
      fallback_prio <= cfg_wdata;
    end
  end

  // task table, status and priority in flops
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_COUNT; i++) begin
        task_status[i]   <= (i == 0) ? TS_IDLE : TS_INVALID;
        task_priority[i] <= '0;
      end
    end else begin
      if (st_we) task_status[st_wa] <= st_wd;
      if (slot_we) task_priority[found_t] <= prio;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) task_entry[found_t] <= entry;
    if (next_we) task_next[tail_rd] <= enq_t;
    next_rd <= task_next[nt];
  end

  always_ff @(posedge clk) begin
    if (head_we) queue_head[qa] <= head_wd;
    if (tail_we) queue_tail[qa] <= enq_t;
    head_rd <= queue_head[qa];
    tail_rd <= queue_tail[qa];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_bitmap <= '0;
    end else begin
      if (rdy_set) ready_bitmap[qa] <= 1'b1;
      if (rdy_clr) ready_bitmap[qa] <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tuser  <= res_code;
        m_tdata  <= {6'd0, 5'(cur_pri_rd), 4'(cur), 4'(from_id),
                     (cur != from_id), 4'(new_id)};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // the idle task is never freed, queued or run as an ordinary task
  a_idle_task: assert property (@(posedge clk) disable iff (rst)
    task_status[0] == TS_IDLE)
    else $error("idle task status changed");

  a_running_state: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cur != '0) |-> task_status[cur] == TS_RUNNING)
    else $error("running task not marked running");

  a_scan_waited: assert property (@(posedge clk) disable iff (rst)
    scan_res.done |-> (state == S_FREE_WAIT || state == S_READY_WAIT))
    else $error("search finished outside a wait state");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_FINISH)
    else $error("result raised outside finish");

endmodule
`default_nettype wire

// ===== src/prqs_scan.sv =====
// Shared bit-search unit: finds the lowest or highest set bit, one chunk a cycle.
`default_nettype none
module prqs_scan #(
  parameter int W = prqs_pkg::DEF_TASK_COUNT,
  localparam int CH   = prqs_pkg::SCAN_CHUNK,
  localparam int NCH  = (W + CH - 1) / CH,
  localparam int PADW = NCH * CH,
  localparam int IW   = $clog2(PADW)
) (
  input  logic                clk,
  input  logic                rst,
  input  prqs_pkg::scan_req_t req,
  input  logic [W-1:0]        vec,
  output prqs_pkg::scan_res_t res,
  output logic [IW-1:0]       idx
);
  import prqs_pkg::*;

  localparam int CBW = $clog2(CH);

  logic            busy;
  logic            desc;
  logic [PADW-1:0] data;
  logic [PADW-1:0] padded;
  logic [PADW-1:0] rev;
  logic [IW-1:0]   base;
  logic [CH-1:0]   chunk;
  logic [CBW-1:0]  pos;
  logic [IW-1:0]   hit_idx;
  logic            hit;
  logic            last;

  assign padded = PADW'(vec);

  always_comb begin
    for (int i = 0; i < PADW; i++) begin
      rev[i] = padded[PADW-1-i];
    end
  end

  assign chunk = data[CH-1:0];
  assign hit   = |chunk;
  assign last  = (base == IW'(PADW - CH));

  always_comb begin
    pos = '0;
    for (int i = CH - 1; i >= 0; i--) begin
      if (chunk[i]) pos = CBW'(i);
    end
  end

  assign hit_idx = base + IW'(pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      res  <= '0;
    end else begin
      res.done <= busy && !req.start && (hit || last);
      if (req.start) begin
        busy <= 1'b1;
        desc <= req.desc;
        base <= '0;
        data <= req.desc ? rev : padded;
      end else if (busy) begin
        if (hit || last) begin
          busy      <= 1'b0;
          res.found <= hit;
          // descending search runs on the mirrored vector
          idx <= desc ? (IW'(PADW - 1) - hit_idx) : hit_idx;
        end else begin
          data <= data >> CH;
          base <= base + IW'(CH);
        end
      end
    end
  end

endmodule
`default_nettype wire
